[rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

[rtl/rrdre_pkg.sv]
package rrdre_pkg;

   // field widths
   localparam int FREQ_W    = 5;
   localparam int CV_W      = 8;
   localparam int BYTE_W    = 8;
   localparam int CNT_W     = 5;

   // up to four bytes leave per row
   localparam int MAX_BYTES = 4;
   localparam int SLOT_W    = 2;
   localparam int NUM_W     = 3;

   // default depth of the command queue
   localparam int QUEUE_DEPTH = 4;

   // stream codes
   localparam logic [CNT_W-1:0]  RUN_LIMIT = 5'd30;
   localparam logic [BYTE_W-1:0] HDR_FULL  = 8'hC0;
   localparam logic [BYTE_W-1:0] HDR_FREQ  = 8'h40;
   localparam logic [BYTE_W-1:0] HDR_VOL   = 8'h20;
   localparam logic [BYTE_W-1:0] CODE_CTRL = 8'h81;
   localparam logic [BYTE_W-1:0] CTRL_MASK = 8'hF0;
   localparam logic [BYTE_W-1:0] END_BYTE  = 8'h00;

   // one queued command: the bytes of one row and the index of its last byte
   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [SLOT_W-1:0]                last_slot;
   } rrdre_cmd_type;

endpackage

[rtl/rrdre_front.sv]
`include "assert_macros.svh"

module rrdre_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [rrdre_pkg::FREQ_W-1:0]  req_freq,
   input  logic [rrdre_pkg::CV_W-1:0]    req_ctrl_vol,
   input  logic                          req_first_row,
   input  logic                          req_last_row,
   output logic                          push,
   output rrdre_pkg::rrdre_cmd_type      cmd
);
   import rrdre_pkg::*;

   logic [FREQ_W-1:0] prev_freq_ff, prev_freq_in;
   logic [CV_W-1:0]   prev_cv_ff, prev_cv_in;
   logic [CNT_W-1:0]  repeat_count_ff, repeat_count_in;
   logic [CNT_W-1:0]  cnt_inc;
   logic [NUM_W-1:0]  num;
   logic              accept;
   logic              same_row;
   logic              same_ctrl;

   assign accept    = req_valid && !req_stall;
   assign same_row  = (req_freq == prev_freq_ff) && (req_ctrl_vol == prev_cv_ff);
   assign same_ctrl = (req_ctrl_vol & CTRL_MASK) == (prev_cv_ff & CTRL_MASK);
   assign cnt_inc   = repeat_count_ff + CNT_W'(1);

   // classify the row and build its byte list
   always_comb begin
      cmd.bytes       = '0;
      num             = '0;
      prev_freq_in    = prev_freq_ff;
      prev_cv_in      = prev_cv_ff;
      repeat_count_in = repeat_count_ff;
      if (req_first_row) begin
         prev_freq_in    = req_freq;
         prev_cv_in      = req_ctrl_vol;
         repeat_count_in = '0;
         cmd.bytes[0]    = HDR_FULL | BYTE_W'(req_freq);
         cmd.bytes[1]    = req_ctrl_vol;
         num             = NUM_W'(2);
      end else if (same_row) begin
         if (cnt_inc >= RUN_LIMIT) begin
            cmd.bytes[0]    = BYTE_W'(cnt_inc);
            num             = NUM_W'(1);
            repeat_count_in = '0;
         end else begin
            repeat_count_in = cnt_inc;
         end
      end else begin
         // flush a pending run first
         if (repeat_count_ff != '0) begin
            cmd.bytes[0] = BYTE_W'(repeat_count_ff);
            num          = NUM_W'(1);
         end
         repeat_count_in = '0;
         if (req_ctrl_vol != prev_cv_ff) begin
            prev_cv_in = req_ctrl_vol;
            if (req_freq != prev_freq_ff) begin
               prev_freq_in              = req_freq;
               cmd.bytes[num[SLOT_W-1:0]] = HDR_FULL | BYTE_W'(req_freq);
               num                       = num + NUM_W'(1);
               cmd.bytes[num[SLOT_W-1:0]] = req_ctrl_vol;
               num                       = num + NUM_W'(1);
            end else if (same_ctrl) begin
               cmd.bytes[num[SLOT_W-1:0]] = HDR_VOL | (req_ctrl_vol & ~CTRL_MASK);
               num                       = num + NUM_W'(1);
            end else begin
               cmd.bytes[num[SLOT_W-1:0]] = CODE_CTRL;
               num                       = num + NUM_W'(1);
               cmd.bytes[num[SLOT_W-1:0]] = req_ctrl_vol;
               num                       = num + NUM_W'(1);
            end
         end else begin
            prev_freq_in              = req_freq;
            cmd.bytes[num[SLOT_W-1:0]] = HDR_FREQ | BYTE_W'(req_freq);
            num                       = num + NUM_W'(1);
         end
      end
      // end of pattern: flush the run and close
      if (req_last_row) begin
         if (repeat_count_in != '0) begin
            cmd.bytes[num[SLOT_W-1:0]] = BYTE_W'(repeat_count_in);
            num                       = num + NUM_W'(1);
         end
         repeat_count_in           = '0;
         cmd.bytes[num[SLOT_W-1:0]] = END_BYTE;
         num                       = num + NUM_W'(1);
      end
      // index of the final byte
      cmd.last_slot = SLOT_W'(num - NUM_W'(1));
   end

   assign push = accept && (num != '0);

   // row history
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_freq_ff    <= '0;
         prev_cv_ff      <= '0;
         repeat_count_ff <= '0;
      end else if (accept) begin
         prev_freq_ff    <= prev_freq_in;
         prev_cv_ff      <= prev_cv_in;
         repeat_count_ff <= repeat_count_in;
      end
   end

   `ASSERT_HOLDS(a_run_below_limit, clock, reset, repeat_count_ff < RUN_LIMIT)

endmodule

[rtl/rrdre_fifo.sv]
`include "assert_macros.svh"

module rrdre_fifo #(
   parameter int DEPTH = rrdre_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rrdre_pkg::rrdre_cmd_type push_cmd,
   input  logic                     pop,
   output rrdre_pkg::rrdre_cmd_type head_cmd,
   output logic                     empty,
   output logic                     full
);
   import rrdre_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W_Q = $clog2(DEPTH + 1);

   rrdre_cmd_type       entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W_Q-1:0]  fill_ff, fill_in;

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == CNT_W_Q'(DEPTH));
   assign head_cmd = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W_Q'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W_Q'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `ASSERT_NEVER(a_no_overflow, clock, reset, push && full)
   `ASSERT_NEVER(a_no_underflow, clock, reset, pop && empty)

endmodule

[rtl/rrdre_back.sv]
`include "assert_macros.svh"

module rrdre_back (
   input  logic                            clock,
   input  logic                            reset,
   input  rrdre_pkg::rrdre_cmd_type        head_cmd,
   input  logic                            empty,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rrdre_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                            rsp_last_of_run
);
   import rrdre_pkg::*;

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              last_ff;
   logic              load;
   logic              at_last;

   // take the next byte when the output register is free or being drained
   assign load    = !empty && (!valid_ff || !rsp_stall);
   assign at_last = (slot_ff == head_cmd.last_slot);
   assign pop     = load && at_last;

   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         slot_in  = at_last ? '0 : slot_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   // output beat payload
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head_cmd.bytes[slot_ff];
         last_ff <= at_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

   `ASSERT_NEVER(a_slot_in_range, clock, reset, !empty && (slot_ff > head_cmd.last_slot))
   `ASSERT_NEVER(a_slot_idle_zero, clock, reset, empty && (slot_ff != '0))

endmodule

[rtl/register_row_delta_rle_encoder.sv]
// Row-delta run-length encoder for sound-register rows.
// Request channel: req_valid / req_stall with one row per beat (req_freq,
// req_ctrl_vol, req_first_row, req_last_row). Response channel: rsp_valid /
// rsp_stall with one encoded byte per beat; rsp_last_of_run marks the final
// byte caused by a row. Rows that only extend a run give no beat.
// A front stage classifies each row in the cycle it is taken, updates the
// row history and pushes one to four bytes as one command into a queue of
// QUEUE_DEPTH entries. A back stage sends one byte per cycle from the queue
// head through a registered output while rsp_stall is low.
// A row's bytes pass through a queue entry, then the registered output.
// Throughput: a row is taken every cycle while the queue has room; the
// sustained rate, set by the single byte-wide output register, is one
// output byte per cycle while rsp_stall is low.
// req_stall rises only when the queue is full; a stalled response holds its
// byte while the front keeps taking rows until the queue fills.
// Reset (synchronous) clears the row history and run count to zero and
// empties the queue and the output register.
module register_row_delta_rle_encoder #(
   parameter int QUEUE_DEPTH = rrdre_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rrdre_pkg::FREQ_W-1:0]  req_freq,
   input  logic [rrdre_pkg::CV_W-1:0]    req_ctrl_vol,
   input  logic                          req_first_row,
   input  logic                          req_last_row,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rrdre_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                          rsp_last_of_run
);
   import rrdre_pkg::*;

   rrdre_cmd_type push_cmd;
   rrdre_cmd_type head_cmd;
   logic          push;
   logic          pop;
   logic          empty;
   logic          full;

   assign req_stall = full;

   // front: classify rows
   rrdre_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_freq      (req_freq),
      .req_ctrl_vol  (req_ctrl_vol),
      .req_first_row (req_first_row),
      .req_last_row  (req_last_row),
      .push          (push),
      .cmd           (push_cmd)
   );

   // command queue
   rrdre_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (empty),
      .full     (full)
   );

   // back: serialize bytes
   rrdre_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_cmd        (head_cmd),
      .empty           (empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

[dv/register_row_delta_rle_encoder_tb.sv]
`timescale 1ns / 100ps

module register_row_delta_rle_encoder_tb;
   import rrdre_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int ROWS_PER_RUN = 140;

   // one encoded byte as it should leave the block
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              tail;
   } enc_byte_type;

   // row history predictor and the bytes still owed by the block
   class row_encoder_model;
      logic [FREQ_W-1:0] last_freq;
      logic [CV_W-1:0]   last_cv;
      logic [CNT_W-1:0]  run_len;
      enc_byte_type      due_bytes[$];
      enc_byte_type      row_bytes[$];
      int                mismatches;

      function new();
         last_freq  = '0;
         last_cv    = '0;
         run_len    = '0;
         mismatches = 0;
      endfunction

      function void emit(logic [BYTE_W-1:0] b);
         enc_byte_type e;
         e.data = b;
         e.tail = 1'b0;
         row_bytes.push_back(e);
      endfunction

      // encode one accepted row and queue its bytes
      function void take_row(logic [FREQ_W-1:0] f, logic [CV_W-1:0] cv,
                             logic first, logic last);
         logic same_ctrl;
         enc_byte_type e;
         row_bytes.delete();
         if (first) begin
            last_freq = f;
            last_cv   = cv;
            run_len   = '0;
            emit({3'b000, f} | HDR_FULL);
            emit(cv);
         end else if (f == last_freq && cv == last_cv) begin
            run_len = run_len + 1'b1;
            if (run_len >= RUN_LIMIT) begin
               emit({3'b000, run_len});
               run_len = '0;
            end
         end else begin
            // flush pending repeats before the change code
            if (run_len != 0) emit({3'b000, run_len});
            run_len = '0;
            if (cv != last_cv) begin
               same_ctrl = (cv & CTRL_MASK) == (last_cv & CTRL_MASK);
               last_cv = cv;
               if (f != last_freq) begin
                  last_freq = f;
                  emit({3'b000, f} | HDR_FULL);
                  emit(cv);
               end else if (same_ctrl) begin
                  emit({4'h0, cv[3:0]} | HDR_VOL);
               end else begin
                  emit(CODE_CTRL);
                  emit(cv);
               end
            end else begin
               last_freq = f;
               emit({3'b000, f} | HDR_FREQ);
            end
         end
         // end of pattern
         if (last) begin
            if (run_len != 0) emit({3'b000, run_len});
            run_len = '0;
            emit(END_BYTE);
         end
         for (int i = 0; i < row_bytes.size(); i++) begin
            e = row_bytes[i];
            e.tail = (i == row_bytes.size() - 1);
            due_bytes.push_back(e);
         end
      endfunction

      // compare one accepted response beat with the oldest owed byte
      function void check_byte(logic [BYTE_W-1:0] data, logic tail);
         enc_byte_type e;
         if (due_bytes.size() == 0) begin
            $display("%0t: unexpected byte %h last_of_run %b", $time, data, tail);
            mismatches++;
            return;
         end
         e = due_bytes.pop_front();
         if (data !== e.data) begin
            $display("%0t: out_byte expected %h actual %h", $time, e.data, data);
            mismatches++;
         end
         if (tail !== e.tail) begin
            $display("%0t: last_of_run expected %b actual %b", $time, e.tail, tail);
            mismatches++;
         end
      endfunction

      function int pending();
         return due_bytes.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [FREQ_W-1:0] req_freq = '0;
   logic [CV_W-1:0]   req_ctrl_vol = '0;
   logic              req_first_row = 1'b0;
   logic              req_last_row = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_last_of_run;

   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                rows_sent = 0;
   int                cycles = 0;
   row_encoder_model  model = new();

   register_row_delta_rle_encoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_freq       (req_freq),
      .req_ctrl_vol   (req_ctrl_vol),
      .req_first_row  (req_first_row),
      .req_last_row   (req_last_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_of_run(rsp_last_of_run)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // random response stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // outputs settle well before the next edge, so sample at the falling edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         model.check_byte(rsp_out_byte, rsp_last_of_run);
      end
   end

   // drive one row and hold it until the beat is taken
   task automatic send_row(logic [FREQ_W-1:0] f, logic [CV_W-1:0] cv,
                           logic first, logic last);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_freq      <= f;
      req_ctrl_vol  <= cv;
      req_first_row <= first;
      req_last_row  <= last;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      model.take_row(f, cv, first, last);
      rows_sent++;
   endtask

   // hold off the sender until every owed byte has been seen
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (model.pending() != 0) @(posedge clock);
   endtask

   // one well-formed pattern: header row, body of deltas and repeats, last row
   task automatic send_pattern();
      logic [FREQ_W-1:0] f;
      logic [FREQ_W-1:0] fd;
      logic [CV_W-1:0]   cv;
      logic [3:0]        nd;
      int                len;
      int                kind;
      int                reps;
      f   = FREQ_W'($urandom);
      cv  = CV_W'($urandom);
      len = $urandom_range(0, 16);
      send_row(f, cv, 1'b1, len == 0);
      for (int k = 1; k <= len; k++) begin
         kind = $urandom_range(0, 9);
         fd   = FREQ_W'($urandom_range(1, 31));
         nd   = 4'($urandom_range(1, 15));
         case (kind)
            4: begin
               f = f ^ fd;
            end
            5: begin
               cv[3:0] = cv[3:0] ^ nd;
            end
            6: begin
               cv[7:4] = cv[7:4] ^ nd;
               if ($urandom_range(1)) cv[3:0] = 4'($urandom);
            end
            7, 8: begin
               f  = f ^ fd;
               cv = cv ^ {nd, 4'($urandom)};
            end
            9: begin
               // long stretch of identical rows that can reach the run limit
               reps = $urandom_range(25, 40);
               repeat (reps) send_row(f, cv, 1'b0, 1'b0);
            end
            default: begin
            end
         endcase
         send_row(f, cv, 1'b0, k == len);
      end
   endtask

   // unstructured rows with random marks
   task automatic send_noise();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) begin
         send_row(FREQ_W'($urandom), CV_W'($urandom),
                  $urandom_range(3) == 0, $urandom_range(3) == 0);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      send_row(5'd0, 8'h00, 1'b0, 1'b0);    // equal to reset history, counted
      send_row(5'd31, 8'hFF, 1'b1, 1'b1);   // first and last together, count dropped
      send_row(5'd31, 8'hFF, 1'b0, 1'b0);
      send_row(5'd31, 8'hFF, 1'b0, 1'b0);
      send_row(5'd5, 8'hFF, 1'b0, 1'b0);    // frequency only, flushes count
      send_row(5'd5, 8'hF0, 1'b0, 1'b0);    // volume only
      send_row(5'd5, 8'h0F, 1'b0, 1'b0);    // control change
      send_row(5'd0, 8'h00, 1'b0, 1'b0);    // full change
      send_row(5'd0, 8'h00, 1'b0, 1'b1);    // repeat then end of pattern
      send_row(5'd7, 8'h3A, 1'b1, 1'b0);
      send_row(5'd7, 8'h3A, 1'b0, 1'b0);
      send_row(5'd7, 8'h3A, 1'b0, 1'b0);
      send_row(5'd9, 8'h55, 1'b1, 1'b0);    // header while repeats pending
      send_row(5'd9, 8'h55, 1'b0, 1'b1);
      send_row(5'd3, 8'h47, 1'b0, 1'b1);    // change on the last row
      send_row(5'd16, 8'hA5, 1'b1, 1'b0);
      send_row(5'd16, 8'hAA, 1'b0, 1'b0);
      send_row(5'd1, 8'hAA, 1'b0, 1'b1);
      drain();

      // random rows in three idling regimes
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 28 : (p == 1) ? 48 : 0;
         recv_idle_pct = (p == 0) ? 48 : (p == 1) ? 28 : 0;
         rows_sent = 0;
         while (rows_sent < ROWS_PER_RUN) begin
            if ($urandom_range(7) == 0) send_noise();
            else send_pattern();
         end
         drain();
      end

      // let stray beats show up
      repeat (20) @(posedge clock);
      if (model.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
